### hw/rtl/cie_pkg.sv
// ----------------------------------------------------------------------------
// cie_pkg - compressed instruction expander definitions
// Opcodes, instruction kinds and the decode/expand functions.
// ----------------------------------------------------------------------------
package cie_pkg;

  localparam int unsigned CWordW = 16;
  localparam int unsigned XWordW = 32;

  localparam logic [6:0] OPC_OP_IMM   = 7'h13;
  localparam logic [6:0] OPC_OP_IMM32 = 7'h1B;
  localparam logic [6:0] OPC_LUI      = 7'h37;
  localparam logic [6:0] OPC_JAL      = 7'h6F;
  localparam logic [6:0] OPC_JALR     = 7'h67;
  localparam logic [6:0] OPC_BRANCH   = 7'h63;
  localparam logic [6:0] OPC_OP       = 7'h33;
  localparam logic [6:0] OPC_SYSTEM   = 7'h73;

  localparam logic [1:0] QUAD_0 = 2'b00;
  localparam logic [1:0] QUAD_1 = 2'b01;
  localparam logic [1:0] QUAD_2 = 2'b10;

  localparam logic [2:0] F3_000 = 3'b000;
  localparam logic [2:0] F3_001 = 3'b001;
  localparam logic [2:0] F3_010 = 3'b010;
  localparam logic [2:0] F3_011 = 3'b011;
  localparam logic [2:0] F3_100 = 3'b100;
  localparam logic [2:0] F3_101 = 3'b101;
  localparam logic [2:0] F3_110 = 3'b110;
  localparam logic [2:0] F3_111 = 3'b111;

  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_RA   = 5'd1;
  localparam logic [4:0] REG_SP   = 5'd2;

  typedef enum logic [3:0] {
    K_NONE,
    K_ADDI4SPN,
    K_ADDI,
    K_LI,
    K_ADDI16SP,
    K_LUI,
    K_JAL,
    K_ADDIW,
    K_J,
    K_BEQZ,
    K_BNEZ,
    K_JR,
    K_JALR,
    K_MV,
    K_ADD,
    K_EBREAK
  } kind_t;

  function automatic kind_t decode_kind(input logic [CWordW-1:0] c, input logic rv64);
    logic [4:0] rd;
    logic [4:0] rs2;
    logic       top;
    kind_t      k;
    rd  = c[11:7];
    rs2 = c[6:2];
    top = c[12];
    k   = K_NONE;
    case (c[1:0])
      QUAD_0: begin
        if (c[15:13] == F3_000 && c != '0) k = K_ADDI4SPN;
      end
      QUAD_1: begin
        case (c[15:13])
          F3_000: k = K_ADDI;
          F3_001: k = rv64 ? K_ADDIW : K_JAL;
          F3_010: k = K_LI;
          F3_011: begin
            if (rd == REG_SP) k = K_ADDI16SP;
            else if (rd != REG_ZERO) k = K_LUI;
          end
          F3_101: k = K_J;
          F3_110: k = K_BEQZ;
          F3_111: k = K_BNEZ;
          default: k = K_NONE;
        endcase
      end
      QUAD_2: begin
        if (c[15:13] == F3_100) begin
          if (rd != REG_ZERO && rs2 == REG_ZERO) k = top ? K_JALR : K_JR;
          else if (!top && rd != REG_ZERO) k = K_MV;
          else if (rd != REG_ZERO) k = K_ADD;
          else if (top && rs2 == REG_ZERO) k = K_EBREAK;
        end
      end
      default: k = K_NONE;
    endcase
    return k;
  endfunction

  function automatic logic [XWordW-1:0] expand(input logic [CWordW-1:0] c,
                                               input kind_t k);
    logic [4:0]  rd;
    logic [4:0]  rs2;
    logic [4:0]  rdp;
    logic [11:0] imm_ci;
    logic [11:0] imm_4spn;
    logic [11:0] imm_16sp;
    logic [9:0]  j_lo;
    logic [5:0]  b_hi;
    logic [3:0]  b_lo;
    logic [XWordW-1:0] w;
    rd       = c[11:7];
    rs2      = c[6:2];
    rdp      = {2'b01, c[9:7]};
    imm_ci   = {{6{c[12]}}, c[12], c[6:2]};
    imm_4spn = {2'b00, c[10:7], c[12:11], c[5], c[6], 2'b00};
    imm_16sp = {{2{c[12]}}, c[12], c[4:3], c[5], c[2], c[6], 4'b0000};
    // C.J/C.JAL offset bits 10:1
    j_lo     = {c[8], c[10:9], c[6], c[7], c[2], c[11], c[5:3]};
    b_hi     = {{3{c[12]}}, c[6:5], c[2]};
    b_lo     = {c[11:10], c[4:3]};
    w        = {{(XWordW-CWordW){1'b0}}, c};
    case (k)
      K_ADDI4SPN: w = {imm_4spn, REG_SP, F3_000, {2'b01, c[4:2]}, OPC_OP_IMM};
      K_ADDI:     w = {imm_ci, rd, F3_000, rd, OPC_OP_IMM};
      K_ADDIW:    w = {imm_ci, rd, F3_000, rd, OPC_OP_IMM32};
      K_LI:       w = {imm_ci, REG_ZERO, F3_000, rd, OPC_OP_IMM};
      K_ADDI16SP: w = {imm_16sp, REG_SP, F3_000, REG_SP, OPC_OP_IMM};
      K_LUI:      w = {{14{c[12]}}, c[12], c[6:2], rd, OPC_LUI};
      K_JAL:      w = {c[12], j_lo, c[12], {8{c[12]}}, REG_RA, OPC_JAL};
      K_J:        w = {c[12], j_lo, c[12], {8{c[12]}}, REG_ZERO, OPC_JAL};
      K_BEQZ:     w = {c[12], b_hi, REG_ZERO, rdp, F3_000, b_lo, c[12], OPC_BRANCH};
      K_BNEZ:     w = {c[12], b_hi, REG_ZERO, rdp, F3_001, b_lo, c[12], OPC_BRANCH};
      K_JR:       w = {12'h000, rd, F3_000, REG_ZERO, OPC_JALR};
      K_JALR:     w = {12'h000, rd, F3_000, REG_RA, OPC_JALR};
      K_MV:       w = {12'h000, rs2, F3_000, rd, OPC_OP_IMM};
      K_ADD:      w = {7'h00, rs2, rd, F3_000, rd, OPC_OP};
      K_EBREAK:   w = {12'h001, REG_ZERO, F3_000, REG_ZERO, OPC_SYSTEM};
      default:    w = {{(XWordW-CWordW){1'b0}}, c};
    endcase
    return w;
  endfunction

endpackage

### hw/rtl/compressed_instruction_expander.sv
// ----------------------------------------------------------------------------
// compressed_instruction_expander - 16-bit to 32-bit instruction expansion
// Pipeline: an input transfer passes the capture, decode and build registers in
// order before the earliest result transfer; out_tvalid rises once build is loaded.
// Throughput: one instruction per cycle while out_tready is high; each stage advances when the next frees.
// Reset: synchronous active-low rst_n empties the pipeline and clears rv64 mode.
// ----------------------------------------------------------------------------
module compressed_instruction_expander (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_wr_en,
  input  logic                        cfg_wr_data,   // rv64_mode
  input  logic                        in_tvalid,
  output logic                        in_tready,
  input  logic [cie_pkg::CWordW-1:0]  in_tdata,      // compressed_word
  output logic                        out_tvalid,
  input  logic                        out_tready,
  output logic [cie_pkg::XWordW-1:0]  out_tdata,     // expanded_word
  output logic                        out_tuser      // recognized
);
  import cie_pkg::*;

  logic rv64_mode_r;

  // stage A: captured word
  logic              va_r;
  logic [CWordW-1:0] word_a_r;
  // stage B: word plus decoded kind
  logic              vb_r;
  logic [CWordW-1:0] word_b_r;
  kind_t             kind_b_r;
  kind_t             kind_nxt;
  // stage C: result register
  logic              vc_r;
  logic [XWordW-1:0] exp_c_r;
  logic              rec_c_r;
  logic [XWordW-1:0] exp_nxt;

  logic ready_a;
  logic ready_b;
  logic ready_c;

  assign ready_c   = !vc_r || out_tready;
  assign ready_b   = !vb_r || ready_c;
  assign ready_a   = !va_r || ready_b;
  assign in_tready = ready_a;

  assign kind_nxt = decode_kind(word_a_r, rv64_mode_r);
  assign exp_nxt  = expand(word_b_r, kind_b_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv64_mode_r <= 1'b0;
    end else if (cfg_wr_en) begin
      rv64_mode_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
    end else begin
      if (ready_a) va_r <= in_tvalid;
      if (ready_b) vb_r <= va_r;
      if (ready_c) vc_r <= vb_r;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_a && in_tvalid) begin
      word_a_r <= in_tdata;
    end
    if (ready_b && va_r) begin
      word_b_r <= word_a_r;
      kind_b_r <= kind_nxt;
    end
    if (ready_c && vb_r) begin
      exp_c_r <= exp_nxt;
      rec_c_r <= (kind_b_r != K_NONE);
    end
  end

  assign out_tvalid = vc_r;
  assign out_tdata  = exp_c_r;
  assign out_tuser  = rec_c_r;

`ifndef SYNTHESIS
  // passed-through words are zero-extended
  a_pass_zext: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> (out_tdata[XWordW-1:CWordW] == '0))
    else $error("unexpanded word not zero-extended");

  // every expanded instruction is a full-length encoding
  a_exp_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[1:0] == 2'b11))
    else $error("expanded instruction lacks 32-bit opcode marker");

  a_in_taken: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> va_r)
    else $error("accepted transfer lost at first stage");

  // a held decode stage keeps its item
  a_b_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vb_r && !ready_c) |=> (vb_r && $stable(kind_b_r) && $stable(word_b_r)))
    else $error("decode stage changed while stalled");
`endif

endmodule
